FILE: rtl/pls_pkg.sv
// Shared types, constants and control structures of the positional list store.
package pls_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int WORD_WIDTH_DEFAULT = 32;

   localparam int FUNC_WIDTH   = 3;
   localparam int POS_WIDTH    = 5;
   localparam int VALUE_WIDTH  = 32;
   localparam int READ_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int LEN_WIDTH    = 5;

   localparam int REQ_DATA_BITS   = POS_WIDTH + VALUE_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS   = READ_WIDTH + LEN_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_DATA_BITS + 7) / 8) * 8;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_APPEND = 3'd0,
      FUNC_GET    = 3'd1,
      FUNC_SET    = 3'd2,
      FUNC_INSERT = 3'd3,
      FUNC_DELETE = 3'd4
   } func_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_NONE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_AT_K,
      RD_BELOW,
      RD_ABOVE
   } rd_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GET_WAIT,
      ST_INS_RD,
      ST_INS_WR,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       mem_rd;
      rd_sel_type rd_sel;
      logic       mem_wr;
      logic       wr_shift;
      logic       idx_load_count;
      logic       idx_load_k;
      logic       idx_dec;
      logic       idx_inc;
      logic       count_inc;
      logic       count_dec;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      func_type   func;
      status_type status;
      logic       idx_at_k;
      logic       del_last;
      logic       rsp_free;
   } stat_type;

endpackage

FILE: rtl/positional_list_store.sv
// Ordered list of up to CAPACITY words with positional append, get, set,
// insert and delete requests, one response per request.
// The request channel carries the operation in req_tuser and the position
// and value in req_tdata; the response channel returns the word read and the
// length in rsp_tdata and the status in rsp_tuser.
// Requests are handled one at a time. Each passes from idle through the
// execute state and its own states to the done state, which loads the
// response, and the next request is taken only back in idle.
// Insert and delete move each element above the target slot through the
// single element memory, one read and one write per element, in
// alternating read and write states. At most CAPACITY-1 elements move.
// Reset empties the list at once; stored words need no clearing because only
// written slots are ever read. While a response waits, the next request is
// still accepted and processed; it is held at its end until the waiting
// response is taken, so a stalled receiver never loses a response.
module positional_list_store import pls_pkg::*; #(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // position [4:0], value [36:5], zero fill above
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // func [2:0]
   input  logic [FUNC_WIDTH-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // read_word [31:0], length [36:32], zero fill above
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // status [1:0]
   output logic [STATUS_WIDTH-1:0]    rsp_tuser
);

   cmd_type  cmd;
   stat_type stat;

   logic [READ_WIDTH-1:0] read_word;
   logic [LEN_WIDTH-1:0]  length;

   pls_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pls_datapath #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_func      (req_tuser),
      .req_position  (req_tdata[POS_WIDTH-1:0]),
      .req_value     (req_tdata[REQ_DATA_BITS-1:POS_WIDTH]),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_read_word (read_word),
      .rsp_status    (rsp_tuser),
      .rsp_length    (length)
   );

   assign rsp_tdata = {{(RSP_TDATA_WIDTH - RSP_DATA_BITS){1'b0}}, length, read_word};

   // A request is taken only when the controller is idle again.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous one is in progress");

   // A full-list response always reports a list at capacity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_FULL) |->
      (length == LEN_WIDTH'(CAPACITY)))
      else $error("full status with a list below capacity");

   // Only a successful get returns a word; errors return zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_DONE) |-> (read_word == '0))
      else $error("word returned with an error status");

   // Every response is loaded by the controller in its final state.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_tvalid)
      else $error("response load did not raise valid");

endmodule

FILE: rtl/pls_control.sv
// Controller state machine that sequences each list request.
module pls_control import pls_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.status != STATUS_DONE) begin
               state_in = ST_DONE;
            end else begin
               case (stat.func)
                  FUNC_APPEND, FUNC_INSERT: begin
                     cmd.idx_load_count = 1'b1;
                     state_in           = ST_INS_RD;
                  end
                  FUNC_GET: begin
                     cmd.mem_rd = 1'b1;
                     cmd.rd_sel = RD_AT_K;
                     state_in   = ST_GET_WAIT;
                  end
                  FUNC_SET: begin
                     cmd.mem_wr = 1'b1;
                     state_in   = ST_DONE;
                  end
                  FUNC_DELETE: begin
                     cmd.idx_load_k = 1'b1;
                     state_in       = ST_DEL_RD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_GET_WAIT: begin
            state_in = ST_DONE;
         end
         // Insert walks down from the end, moving each element up by one.
         ST_INS_RD: begin
            if (stat.idx_at_k) begin
               cmd.mem_wr    = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_BELOW;
               state_in   = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_in     = ST_INS_RD;
         end
         // Delete walks up from the removed slot, moving each element down.
         ST_DEL_RD: begin
            if (stat.del_last) begin
               cmd.count_dec = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_ABOVE;
               state_in   = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = ST_DEL_RD;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/pls_datapath.sv
// Datapath: element memory, length counter, walk index and response register.
module pls_datapath import pls_pkg::*; #(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [FUNC_WIDTH-1:0]   req_func,
   input  logic [POS_WIDTH-1:0]    req_position,
   input  logic [VALUE_WIDTH-1:0]  req_value,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [READ_WIDTH-1:0]   rsp_read_word,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [LEN_WIDTH-1:0]    rsp_length
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   logic [WORD_WIDTH-1:0] mem [CAPACITY];

   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         k_ff, k_in;
   func_type              func_ff, func_in;
   status_type            status_ff, status_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic [WORD_WIDTH-1:0] rdata_ff;
   logic                  rsp_valid_ff;
   logic [READ_WIDTH-1:0] rsp_word_ff;
   status_type            rsp_status_ff;
   logic [LEN_WIDTH-1:0]  rsp_length_ff;

   logic [XW-1:0]         pos_x, cnt_x, pos_m1, clamp_get, clamp_ins, idx_next_x;
   logic                  full;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;
   logic [WORD_WIDTH+VALUE_WIDTH-1:0] word_ext;
   logic [READ_WIDTH+WORD_WIDTH-1:0]  read_ext;

   // Decode of a new request against the length held before it.
   always_comb begin
      pos_x     = XW'(req_position);
      cnt_x     = XW'(count_ff);
      pos_m1    = (pos_x == '0) ? '0 : pos_x - XW'(1);
      clamp_get = ((pos_x < cnt_x) ? pos_x : cnt_x) - XW'(1);
      clamp_ins = (pos_m1 > cnt_x) ? cnt_x : pos_m1;
      full      = (count_ff == CW'(CAPACITY));
      func_in   = func_type'(req_func);
      word_ext  = {{WORD_WIDTH{1'b0}}, req_value};
      word_in   = word_ext[WORD_WIDTH-1:0];
      status_in = STATUS_DONE;
      k_in      = '0;
      case (func_in)
         FUNC_APPEND: begin
            status_in = full ? STATUS_FULL : STATUS_DONE;
            k_in      = cnt_x[AW-1:0];
         end
         FUNC_GET, FUNC_SET: begin
            status_in = (pos_x == '0 || cnt_x == '0) ? STATUS_NONE : STATUS_DONE;
            k_in      = clamp_get[AW-1:0];
         end
         FUNC_INSERT: begin
            status_in = full ? STATUS_FULL : STATUS_DONE;
            k_in      = clamp_ins[AW-1:0];
         end
         FUNC_DELETE: begin
            status_in = (pos_m1 >= cnt_x) ? STATUS_NONE : STATUS_DONE;
            k_in      = pos_m1[AW-1:0];
         end
         default: begin
            status_in = STATUS_DONE;
            k_in      = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff   <= func_in;
         status_ff <= status_in;
         k_ff      <= k_in;
         word_ff   <= word_in;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_load_count) begin
         idx_in = count_ff[AW-1:0];
      end else if (cmd.idx_load_k) begin
         idx_in = k_ff;
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - AW'(1);
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_AT_K:  rd_addr = k_ff;
         RD_BELOW: rd_addr = idx_ff - AW'(1);
         RD_ABOVE: rd_addr = idx_ff + AW'(1);
         default:  rd_addr = k_ff;
      endcase
      wr_addr = cmd.wr_shift ? idx_ff : k_ff;
      wr_data = cmd.wr_shift ? rdata_ff : word_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign idx_next_x = XW'(idx_ff) + XW'(1);
   assign read_ext   = {{READ_WIDTH{1'b0}}, rdata_ff};

   // The response register frees up in the same cycle that its result is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_word_ff   <= (func_ff == FUNC_GET && status_ff == STATUS_DONE) ?
                          read_ext[READ_WIDTH-1:0] : '0;
         rsp_status_ff <= status_ff;
         rsp_length_ff <= cnt_x[LEN_WIDTH-1:0];
      end
   end

   assign stat.func     = func_ff;
   assign stat.status   = status_ff;
   assign stat.idx_at_k = (idx_ff == k_ff);
   assign stat.del_last = (idx_next_x >= cnt_x);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_word = rsp_word_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_length    = rsp_length_ff;

endmodule
